// ===== src/packet_rule_table_classifier_unit_defines.svh =====
// Assertion macros shared by the packet rule table classifier.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef PACKET_RULE_TABLE_CLASSIFIER_UNIT_DEFINES_SVH
`define PACKET_RULE_TABLE_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PRTC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("packet rule table assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PRTC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("packet rule table assertion failed");

`endif

// ===== src/prtc_pkg.sv =====
// Shared types, constants and the rule match function of the rule table classifier.
// Depends on nothing; used by the controller, the datapath and the top level.
package prtc_pkg;

    localparam int DEFAULT_MAX_RULES = 64;
    localparam int MATCH_INDEX_W     = 6;
    localparam int RULE_TOTAL_W      = 7;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_CHECK  = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] mask;
        logic [7:0]  protocol;
        logic [15:0] port;
        logic        permit;
    } t_rule;

    typedef struct packed {
        t_cmd        command;
        t_rule       rule;
        logic [31:0] pkt_addr;
        logic [7:0]  pkt_protocol;
        logic [15:0] pkt_port;
    } t_req;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic do_add;
        logic do_clear;
        logic rd_req;
        logic shift_wr;
        logic dec_count;
        logic set_full;
        logic set_not_found;
        logic set_block;
        logic out_load;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd command;
        logic full;
        logic empty;
        logic hit;
        logic last;
        logic more;
        logic out_free;
    } t_dp_stat;

    // True when a deny rule covers the packet.
    function automatic logic deny_match(input t_rule rule, input logic [31:0] pkt_addr,
                                        input logic [7:0] pkt_protocol,
                                        input logic [15:0] pkt_port);
        logic addr_ok;
        logic proto_ok;
        logic port_ok;
        addr_ok  = (pkt_addr & rule.mask) == (rule.addr & rule.mask);
        proto_ok = (rule.protocol == 8'd0) || (rule.protocol == pkt_protocol);
        port_ok  = (rule.port == 16'd0) || (rule.port == pkt_port);
        return !rule.permit && addr_ok && proto_ok && port_ok;
    endfunction

endpackage

// ===== src/prtc_if.sv =====
// Request and response channel interfaces of the rule table classifier.
// Depends on nothing; instantiated around the top level.
interface prtc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] rule_src_addr;
    logic [31:0] rule_mask;
    logic [7:0]  rule_protocol;
    logic [15:0] rule_port;
    logic        rule_permit;
    logic [31:0] pkt_src_addr;
    logic [7:0]  pkt_protocol;
    logic [15:0] pkt_src_port;

    modport source (
        output valid, command, rule_src_addr, rule_mask, rule_protocol, rule_port,
               rule_permit, pkt_src_addr, pkt_protocol, pkt_src_port,
        input  ready
    );
    modport sink (
        input  valid, command, rule_src_addr, rule_mask, rule_protocol, rule_port,
               rule_permit, pkt_src_addr, pkt_protocol, pkt_src_port,
        output ready
    );
endinterface

interface prtc_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       blocked;
    logic [5:0] match_index;
    logic [6:0] rule_total;

    modport source (
        output valid, status, blocked, match_index, rule_total,
        input  ready
    );
    modport sink (
        input  valid, status, blocked, match_index, rule_total,
        output ready
    );
endinterface

// ===== src/prtc_ctrl.sv =====
// Controller state machine of the rule table classifier.
// Depends on prtc_pkg; drives the datapath through t_ctrl_cmd and reads t_dp_stat.
module prtc_ctrl import prtc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.command) inside
                    CMD_ADD: begin
                        if (i_stat.full) begin
                            o_cmd.set_full = 1'b1;
                        end else begin
                            o_cmd.do_add = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    CMD_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                        n_state        = S_DONE;
                    end
                    CMD_DELETE, CMD_CHECK: begin
                        if (i_stat.empty) begin
                            o_cmd.set_not_found = (i_stat.command == CMD_DELETE);
                            n_state             = S_DONE;
                        end else begin
                            o_cmd.rd_req = 1'b1;
                            n_state      = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.rd_req = 1'b1;
                if (i_stat.hit) begin
                    if (i_stat.command == CMD_DELETE) begin
                        n_state = S_SHIFT;
                    end else begin
                        o_cmd.set_block = 1'b1;
                        n_state         = S_DONE;
                    end
                end else if (i_stat.last) begin
                    o_cmd.set_not_found = (i_stat.command == CMD_DELETE);
                    n_state             = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.rd_req   = 1'b1;
                o_cmd.shift_wr = 1'b1;
                if (!i_stat.more) begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/prtc_dp.sv =====
// Datapath of the rule table classifier: rule memory, counters, compare and result register.
// Depends on prtc_pkg; commanded by prtc_ctrl.
module prtc_dp import prtc_pkg::*; #(
    parameter int MAX_RULES = DEFAULT_MAX_RULES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl_cmd                i_cmd,
    input  t_req                     i_req_data,
    input  logic                     i_out_ready,
    output t_dp_stat                 o_stat,
    output logic                     o_out_valid,
    output logic [1:0]               o_status,
    output logic                     o_blocked,
    output logic [MATCH_INDEX_W-1:0] o_match_index,
    output logic [RULE_TOTAL_W-1:0]  o_rule_total
);

    localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_RULES);

    t_rule r_mem [MAX_RULES];

    t_req          r_item;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_ptr;
    t_rule         r_rd_data;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vld;

    logic [1:0]    r_status;
    logic          r_blocked;
    logic [IW-1:0] r_where;

    logic                     r_out_vld;
    logic [1:0]               r_out_status;
    logic                     r_out_blocked;
    logic [MATCH_INDEX_W-1:0] r_out_index;
    logic [RULE_TOTAL_W-1:0]  r_out_total;

    logic          rd_en;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_rule         wr_data;
    logic          out_free;

    assign rd_en    = i_cmd.rd_req && (r_ptr < r_count);
    assign wr_en    = i_cmd.do_add || (i_cmd.shift_wr && r_rd_vld);
    assign wr_addr  = i_cmd.do_add ? r_count[IW-1:0] : (r_rd_idx - IW'(1));
    assign wr_data  = i_cmd.do_add ? r_item.rule : r_rd_data;
    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_count = r_count;
        if (i_cmd.do_clear) begin
            n_count = '0;
        end else if (i_cmd.do_add) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.dec_count) begin
            n_count = r_count - CW'(1);
        end
    end

    // Rule memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item    <= i_req_data;
            r_ptr     <= '0;
            r_status  <= ST_DONE;
            r_blocked <= 1'b0;
            r_where   <= '0;
        end else begin
            if (rd_en) begin
                r_ptr    <= r_ptr + CW'(1);
                r_rd_idx <= r_ptr[IW-1:0];
            end
            if (i_cmd.set_full) begin
                r_status <= ST_FULL;
            end
            if (i_cmd.set_not_found) begin
                r_status <= ST_NOT_FOUND;
            end
            if (i_cmd.set_block) begin
                r_blocked <= 1'b1;
                r_where   <= r_rd_idx;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status  <= r_status;
            r_out_blocked <= r_blocked;
            r_out_index   <= MATCH_INDEX_W'(r_where);
            r_out_total   <= RULE_TOTAL_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_vld <= rd_en;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.command  = r_item.command;
        o_stat.full     = (r_count == MaxCount);
        o_stat.empty    = (r_count == '0);
        o_stat.hit      = (r_item.command == CMD_DELETE)
                          ? (r_rd_data == r_item.rule)
                          : deny_match(r_rd_data, r_item.pkt_addr, r_item.pkt_protocol,
                                       r_item.pkt_port);
        o_stat.last     = ((CW'(r_rd_idx) + CW'(1)) == r_count);
        o_stat.more     = (r_ptr < r_count);
        o_stat.out_free = out_free;
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_blocked     = r_out_blocked;
    assign o_match_index = r_out_index;
    assign o_rule_total  = r_out_total;

endmodule

// ===== src/packet_rule_table_classifier_unit.sv =====
// Channel      | Direction | Transaction content
// i_req        | in        | command, rule fields (add, delete), packet fields (check)
// o_rsp        | out       | status, blocked, match_index, rule_total
//
// Add and clear step through acceptance, the execute state and the result load.
// Check walks the rules in order up to the first deny match, visiting at most MAX_RULES.
// Delete walks the table up to the match, then moves the rules behind it up one place
// one by one, as the shift shares the single read and write port of memory.
// Reset (synchronous, active low) empties the table; rule memory contents are not cleared.
// A result waiting in the output register does not stop the next transaction from
// being accepted; the block waits only when a new result is ready and the old one is unread.
`include "packet_rule_table_classifier_unit_defines.svh"

module packet_rule_table_classifier_unit import prtc_pkg::*; #(
    parameter int MAX_RULES = DEFAULT_MAX_RULES
) (
    input logic       i_clk,
    input logic       i_rst_n,
    prtc_req_if.sink  i_req,
    prtc_rsp_if.source o_rsp
);

    // Command and status groups between the controller and the datapath.
    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;
    t_req      req_data;

    // Gather the request payload into one word for the datapath's capture register.
    always_comb begin
        req_data.command       = t_cmd'(i_req.command);
        req_data.rule.addr     = i_req.rule_src_addr;
        req_data.rule.mask     = i_req.rule_mask;
        req_data.rule.protocol = i_req.rule_protocol;
        req_data.rule.port     = i_req.rule_port;
        req_data.rule.permit   = i_req.rule_permit;
        req_data.pkt_addr      = i_req.pkt_src_addr;
        req_data.pkt_protocol  = i_req.pkt_protocol;
        req_data.pkt_port      = i_req.pkt_src_port;
    end

    // The controller sequences one transaction at a time: capture, execute,
    // scan the table where needed, shift for a delete, then hand the result over.
    prtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    // The datapath holds the rules in order, walks them one per cycle and
    // owns the output register that decouples the response channel.
    prtc_dp #(
        .MAX_RULES (MAX_RULES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .i_req_data    (req_data),
        .i_out_ready   (o_rsp.ready),
        .o_stat        (dp_stat),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_blocked     (o_rsp.blocked),
        .o_match_index (o_rsp.match_index),
        .o_rule_total  (o_rsp.rule_total)
    );

    // One transaction at a time: the cycle after acceptance the input is closed.
    `PRTC_ASSERT_NXT(a_one_in_flight, i_req.valid && i_req.ready, !i_req.ready)
    // The controller never appends to a full table.
    `PRTC_ASSERT_IMP(a_no_add_when_full, ctrl_cmd.do_add, !dp_stat.full)
    // A delete only shrinks a table that holds rules.
    `PRTC_ASSERT_IMP(a_no_dec_when_empty, ctrl_cmd.dec_count, !dp_stat.empty)
    // A blocked packet always reports a plain done status.
    `PRTC_ASSERT_IMP(a_block_status, o_rsp.valid && o_rsp.blocked, o_rsp.status == ST_DONE)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the packet rule table classifier (add, delete, clear, check).
// Depends on prtc_pkg, the prtc_req_if / prtc_rsp_if interfaces and the top level RTL.
module tb_top;
    import prtc_pkg::*;

    localparam int NUM_RULES      = DEFAULT_MAX_RULES;
    // A check or delete may walk the whole table; the drain allows for that plus a stall.
    localparam int DRAIN_CYCLES   = 200;
    // Cycles with no transaction on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;

    // One expected response transaction, field for field.
    typedef struct packed {
        logic [1:0] status;
        logic       blocked;
        logic [5:0] match_index;
        logic [6:0] rule_total;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    prtc_req_if req_ch ();
    prtc_rsp_if rsp_ch ();

    packet_rule_table_classifier_unit #(
        .MAX_RULES(NUM_RULES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the rule table, updated whenever a request transaction is accepted.
    t_rule       tbl_rules [NUM_RULES];
    int unsigned tbl_count;
    t_verdict    verdict_q [$];
    int          mismatches;

    // Sender burst control: a burst ends after burst_left transactions, then an optional gap.
    int burst_left;
    bit gaps_on;

    // Receiver stall pattern state.
    int       rx_mode;
    int       rx_mode_left;
    int       rx_hold_left;
    int       rx_phase;
    int       idle_cycles;
    t_verdict exp_v;

    // Applies one request to the shadow table and returns the response the block owes.
    // Rules are kept in insertion order; delete closes the hole so order is preserved.
    function automatic t_verdict apply_to_table(input t_req r);
        t_verdict v;
        int       hit;
        int       i;
        int       j;
        t_rule    rl;
        v   = '0;
        hit = -1;
        case (r.command)
            CMD_ADD: begin
                if (tbl_count >= NUM_RULES) begin
                    v.status = ST_FULL;
                end else begin
                    tbl_rules[tbl_count] = r.rule;
                    tbl_count++;
                end
            end
            CMD_DELETE: begin
                for (i = 0; i < tbl_count; i++) begin
                    if (hit < 0 && tbl_rules[i] == r.rule) hit = i;
                end
                if (hit < 0) begin
                    v.status = ST_NOT_FOUND;
                end else begin
                    for (j = hit; j + 1 < tbl_count; j++) tbl_rules[j] = tbl_rules[j + 1];
                    tbl_count--;
                end
            end
            CMD_CLEAR: begin
                tbl_count = 0;
            end
            default: begin
                // First deny rule whose masked address, protocol and port all agree.
                // A zero protocol or port in the rule acts as a wildcard.
                for (i = 0; i < tbl_count; i++) begin
                    rl = tbl_rules[i];
                    if (!v.blocked && !rl.permit &&
                        ((r.pkt_addr & rl.mask) == (rl.addr & rl.mask)) &&
                        (rl.protocol == 8'd0 || rl.protocol == r.pkt_protocol) &&
                        (rl.port == 16'd0 || rl.port == r.pkt_port)) begin
                        v.blocked     = 1'b1;
                        v.match_index = i[5:0];
                    end
                end
            end
        endcase
        v.rule_total = tbl_count[6:0];
        return v;
    endfunction

    // Masks come as full, empty, prefix or arbitrary patterns.
    function automatic logic [31:0] rand_mask();
        int n;
        n = $urandom_range(0, 32);
        case ($urandom_range(0, 4))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            2:       return $urandom;
            default: return (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - n));
        endcase
    endfunction

    function automatic t_rule rand_rule();
        t_rule rl;
        rl.addr     = $urandom;
        rl.mask     = rand_mask();
        rl.protocol = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        rl.port     = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        rl.permit   = ($urandom_range(0, 2) == 0);
        return rl;
    endfunction

    function automatic t_rule make_rule(input logic [31:0] addr, input logic [31:0] mask,
                                        input logic [7:0] proto, input logic [15:0] port,
                                        input logic permit);
        t_rule rl;
        rl.addr     = addr;
        rl.mask     = mask;
        rl.protocol = proto;
        rl.port     = port;
        rl.permit   = permit;
        return rl;
    endfunction

    // Flips one bit anywhere in a rule, giving a near miss for delete.
    function automatic t_rule nudge_rule(input t_rule rl);
        logic [$bits(t_rule)-1:0] bits;
        bits = rl;
        bits[$urandom_range(0, $bits(t_rule) - 1)] ^= 1'b1;
        return t_rule'(bits);
    endfunction

    // Every field carries random content; the ones the command ignores stay as noise.
    function automatic t_req noise_req(input t_cmd c);
        t_req r;
        r.command      = c;
        r.rule         = rand_rule();
        r.pkt_addr     = $urandom;
        r.pkt_protocol = 8'($urandom);
        r.pkt_port     = 16'($urandom);
        return r;
    endfunction

    function automatic t_req rule_req(input t_cmd c, input t_rule rl);
        t_req r;
        r      = noise_req(c);
        r.rule = rl;
        return r;
    endfunction

    function automatic t_req pkt_req(input logic [31:0] addr, input logic [7:0] proto,
                                     input logic [15:0] port);
        t_req r;
        r              = noise_req(CMD_CHECK);
        r.pkt_addr     = addr;
        r.pkt_protocol = proto;
        r.pkt_port     = port;
        return r;
    endfunction

    // Shapes the packet of a check so that it falls under the given rule, and now and
    // then knocks one packet bit off so that it may only just miss.
    function automatic t_req aim_packet(input t_req r, input t_rule rl);
        t_req       a;
        logic [55:0] pkt_bits;
        a          = r;
        a.pkt_addr = (rl.addr & rl.mask) | (r.pkt_addr & ~rl.mask);
        if (rl.protocol != 8'd0) a.pkt_protocol = rl.protocol;
        if (rl.port != 16'd0) a.pkt_port = rl.port;
        if ($urandom_range(0, 3) == 0) begin
            pkt_bits = {a.pkt_addr, a.pkt_protocol, a.pkt_port};
            pkt_bits[$urandom_range(0, 55)] ^= 1'b1;
            {a.pkt_addr, a.pkt_protocol, a.pkt_port} = pkt_bits;
        end
        return a;
    endfunction

    function automatic t_rule some_stored_rule();
        return tbl_rules[$urandom_range(0, tbl_count - 1)];
    endfunction

    // Presents one request transaction and holds it until the block accepts it.
    // Valid stays high across back-to-back transactions inside a burst; it is only
    // lowered when a gap follows, so it never gets two assignments in one step.
    task automatic send_req(input t_req r);
        int gap;
        req_ch.valid         <= 1'b1;
        req_ch.command       <= r.command;
        req_ch.rule_src_addr <= r.rule.addr;
        req_ch.rule_mask     <= r.rule.mask;
        req_ch.rule_protocol <= r.rule.protocol;
        req_ch.rule_port     <= r.rule.port;
        req_ch.rule_permit   <= r.rule.permit;
        req_ch.pkt_src_addr  <= r.pkt_addr;
        req_ch.pkt_protocol  <= r.pkt_protocol;
        req_ch.pkt_src_port  <= r.pkt_port;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        verdict_q.push_back(apply_to_table(r));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) :
                                                    $urandom_range(0, 6);
                if (gap > 0) begin
                    req_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    // Empty table: a check never blocks, a delete finds nothing, a clear is harmless.
    task automatic test_empty_table;
        send_req(pkt_req(32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
        send_req(pkt_req(32'h0, 8'h00, 16'h0000));
        send_req(rule_req(CMD_DELETE, rand_rule()));
        send_req(noise_req(CMD_CLEAR));
    endtask

    // Wildcards, masks, permit rules that the check walks past, and the reported match index.
    task automatic test_match_rules;
        send_req(rule_req(CMD_ADD, make_rule(32'h0, 32'h0, 8'd0, 16'd0, 1'b1)));
        send_req(rule_req(CMD_ADD, make_rule(32'hC0A8_0100, 32'hFFFF_FF00, 8'd6, 16'd80,
                                             1'b0)));
        send_req(rule_req(CMD_ADD, make_rule(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF,
                                             1'b0)));
        send_req(rule_req(CMD_ADD, make_rule(32'h0, 32'h0, 8'd17, 16'd0, 1'b0)));
        send_req(pkt_req(32'hC0A8_01A5, 8'd6, 16'd80));
        send_req(pkt_req(32'hC0A8_01A5, 8'd6, 16'd81));
        send_req(pkt_req(32'h1234_5678, 8'd17, 16'hBEEF));
        send_req(pkt_req(32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
        send_req(pkt_req(32'hFFFF_FFFF, 8'hFF, 16'hFFFE));
        send_req(pkt_req(32'h0, 8'h00, 16'h0000));
    endtask

    // Delete removes only the first of two equal rules and the rules behind it move up.
    task automatic test_delete_order;
        t_rule rule_a;
        t_rule rule_b;
        rule_a = make_rule(32'h0A00_0001, 32'hFFFF_FFFF, 8'd6, 16'd22, 1'b0);
        rule_b = make_rule(32'h0B00_0000, 32'hFF00_0000, 8'd0, 16'd0, 1'b0);
        send_req(noise_req(CMD_CLEAR));
        send_req(rule_req(CMD_ADD, rule_a));
        send_req(rule_req(CMD_ADD, rule_b));
        send_req(rule_req(CMD_ADD, rule_a));
        send_req(pkt_req(32'h0A00_0001, 8'd6, 16'd22));
        send_req(rule_req(CMD_DELETE, rule_a));
        send_req(pkt_req(32'h0A00_0001, 8'd6, 16'd22));
        send_req(rule_req(CMD_DELETE, nudge_rule(rule_a)));
        send_req(rule_req(CMD_DELETE, rule_b));
        send_req(rule_req(CMD_DELETE, rule_a));
        send_req(rule_req(CMD_DELETE, rule_a));
        send_req(rule_req(CMD_ADD, rule_b));
        send_req(noise_req(CMD_CLEAR));
    endtask

    // Fills the table to the last slot, with the only deny rule at the highest index,
    // then pushes past full and deletes from the front and from the back of the table.
    task automatic test_table_full;
        t_req  r;
        t_rule last_deny;
        int    k;
        last_deny = make_rule(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b0);
        send_req(noise_req(CMD_CLEAR));
        for (k = 0; k < NUM_RULES - 1; k++) begin
            r = noise_req(CMD_ADD);
            r.rule.permit = 1'b1;
            send_req(r);
        end
        send_req(rule_req(CMD_ADD, last_deny));
        send_req(rule_req(CMD_ADD, rand_rule()));
        send_req(rule_req(CMD_ADD, rand_rule()));
        send_req(pkt_req(32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
        send_req(aim_packet(noise_req(CMD_CHECK), last_deny));
        send_req(rule_req(CMD_DELETE, tbl_rules[0]));
        send_req(pkt_req(32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
        send_req(rule_req(CMD_ADD, last_deny));
        send_req(rule_req(CMD_DELETE, last_deny));
        send_req(rule_req(CMD_DELETE, tbl_rules[tbl_count - 1]));
        send_req(pkt_req(32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
    endtask

    // Random traffic in phases that grow, hold or shrink the table. Most deletes and
    // checks are aimed at stored rules so that hits, shifts and deep walks happen often.
    task automatic test_random_mix(input int n_items);
        t_req r;
        int   n;
        int   pick;
        int   add_w;
        int   del_w;
        int   clr_w;
        add_w = 30;
        del_w = 30;
        clr_w = 2;
        for (n = 0; n < n_items; n++) begin
            if (n % 250 == 0) begin
                case ($urandom_range(0, 3))
                    0:       begin add_w = 60; del_w = 10; end
                    1:       begin add_w = 30; del_w = 30; end
                    2:       begin add_w = 15; del_w = 45; end
                    default: begin add_w = 45; del_w = 20; end
                endcase
                clr_w   = $urandom_range(0, 3);
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < clr_w) begin
                r = noise_req(CMD_CLEAR);
            end else if (pick < clr_w + add_w) begin
                r = noise_req(CMD_ADD);
                if (tbl_count > 0 && $urandom_range(0, 7) == 0) r.rule = some_stored_rule();
            end else if (pick < clr_w + add_w + del_w) begin
                r = noise_req(CMD_DELETE);
                if (tbl_count > 0 && $urandom_range(0, 9) < 7) begin
                    r.rule = some_stored_rule();
                    if ($urandom_range(0, 4) == 0) r.rule = nudge_rule(r.rule);
                end
            end else begin
                r = noise_req(CMD_CHECK);
                if (tbl_count > 0 && $urandom_range(0, 9) < 6) begin
                    r = aim_packet(r, some_stored_rule());
                end
            end
            send_req(r);
        end
    endtask

    // Lets the last responses arrive, waits out the block's longest walk so that a
    // stray extra response is caught, and then gives the verdict.
    task automatic finish_run;
        req_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    endtask

    // Receiver: the response ready follows a pattern that is drawn anew when rx_mode_left runs
    // out: always ready, coin toss, one cycle in four, or long stalls with short windows.
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(64, 256);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= (rx_phase % 4 == 0);
            default: begin
                if (rx_hold_left != 0) begin
                    rx_hold_left <= rx_hold_left - 1;
                end else begin
                    rsp_ch.ready <= !rsp_ch.ready;
                    rx_hold_left <= rsp_ch.ready ? $urandom_range(10, 40) :
                                                   $urandom_range(1, 5);
                end
            end
        endcase
    end

    // Every accepted response transaction is held against the oldest expectation.
    // Values read here are those from before the edge, so ordering within the step is moot.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: response with nothing expected: status %0d blocked %0d index %0d total %0d",
                         $time, rsp_ch.status, rsp_ch.blocked, rsp_ch.match_index,
                         rsp_ch.rule_total);
                mismatches++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (rsp_ch.status !== exp_v.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_v.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.blocked !== exp_v.blocked) begin
                    $display("%0t: blocked expected %0d actual %0d",
                             $time, exp_v.blocked, rsp_ch.blocked);
                    mismatches++;
                end
                if (rsp_ch.match_index !== exp_v.match_index) begin
                    $display("%0t: match_index expected %0d actual %0d",
                             $time, exp_v.match_index, rsp_ch.match_index);
                    mismatches++;
                end
                if (rsp_ch.rule_total !== exp_v.rule_total) begin
                    $display("%0t: rule_total expected %0d actual %0d",
                             $time, exp_v.rule_total, rsp_ch.rule_total);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel means a hang.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // Every input of the block is known from time zero.
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_ADD;
        req_ch.rule_src_addr = '0;
        req_ch.rule_mask     = '0;
        req_ch.rule_protocol = '0;
        req_ch.rule_port     = '0;
        req_ch.rule_permit   = 1'b0;
        req_ch.pkt_src_addr  = '0;
        req_ch.pkt_protocol  = '0;
        req_ch.pkt_src_port  = '0;
        rsp_ch.ready         = 1'b0;
        rx_mode              = 0;
        rx_mode_left         = 0;
        rx_hold_left         = 0;
        rx_phase             = 0;
        idle_cycles          = 0;
        tbl_count            = 0;
        mismatches           = 0;
        burst_left           = 0;
        gaps_on              = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table;
        test_match_rules;
        test_delete_order;
        test_table_full;
        test_random_mix(1600);
        finish_run;
    end

endmodule
